// ===== sv/assert_macros.svh =====
// Assertion helper macros for the token deframer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LTD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");
`define LTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");
`else
`define LTD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LTD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/ltd_pkg.sv =====
// Shared types and constants for the length-prefixed token deframer.
// No dependencies; imported by all deframer modules.
package ltd_pkg;

    localparam int MAX_STRING_LEN_DEF = 4096;
    localparam int OUT_DATA_W         = 48;

    localparam logic [7:0]  CH_HASH   = 8'h23;
    localparam logic [7:0]  CH_COLON  = 8'h3A;
    localparam logic [7:0]  CH_TILDE  = 8'h7E;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [34:0] INT_LIMIT = 35'd2147483647;
    localparam logic [34:0] RADIX     = 35'd10;

    typedef enum logic [8:0] {
        PH_PFX1    = 9'b000000001,
        PH_PFX2    = 9'b000000010,
        PH_DIG1    = 9'b000000100,
        PH_DIGN    = 9'b000001000,
        PH_SPFX1   = 9'b000010000,
        PH_SPFX2   = 9'b000100000,
        PH_PAYLOAD = 9'b001000000,
        PH_SSUF    = 9'b010000000,
        PH_DROP    = 9'b100000000
    } t_phase;

    typedef enum logic [1:0] {
        K_PAYLOAD = 2'd0,
        K_INT     = 2'd1,
        K_STR     = 2'd2,
        K_ERR     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        E_PREFIX  = 3'd0,
        E_DIGIT   = 3'd1,
        E_NODIGIT = 3'd2,
        E_SUFFIX  = 3'd3,
        E_LARGE   = 3'd4,
        E_TRUNC   = 3'd5
    } t_err;

    // Packed so that {error_code, payload_byte, value} maps straight onto tdata.
    typedef struct packed {
        t_kind       kind;
        t_err        error_code;
        logic [7:0]  payload_byte;
        logic [30:0] value;
    } t_result;

endpackage

// ===== sv/length_prefixed_token_deframer_unit.sv =====
// Top level of the length-prefixed token deframer: input beat register,
// parser and result buffer. Depends on ltd_pkg, ltd_parser, ltd_out_buf.
//
//  channel   dir  tdata                               tuser       tlast
//  s_axis    in   in_byte[7:0]                        mode[0]     end_of_message
//  m_axis    out  value[30:0] payload_byte[38:31]     kind[1:0]   -
//                 error_code[41:39] zero pad[47:42]
//
// One input beat per cycle while the result buffer has room; a result passes
// through the input register, then the result buffer, before it leaves.
// The input register advances whenever the two-entry result buffer has room.
// Reset is synchronous, active low, and returns the parser to the first
// prefix byte. A stall on m_axis fills the buffer, then holds s_axis off.
`include "assert_macros.svh"

module length_prefixed_token_deframer_unit #(
    parameter int MAX_STRING_LEN = ltd_pkg::MAX_STRING_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [7:0]                     i_s_axis_tdata,  // in_byte
    input  logic [0:0]                     i_s_axis_tuser,  // mode
    input  logic                           i_s_axis_tlast,  // end_of_message
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // value[30:0], payload_byte[38:31], error_code[41:39], zeros above
    output logic [ltd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]                     o_m_axis_tuser   // kind
);
    import ltd_pkg::*;

    logic       r_in_valid;
    logic       r_in_mode;
    logic [7:0] r_in_byte;
    logic       r_in_eom;

    logic       advance;
    logic       res_valid;
    t_result    res;
    logic       buf_space;
    logic       buf_valid;
    logic [1:0] buf_level;
    t_result    head;
    logic       s_fire;
    logic       pop;

    assign advance         = r_in_valid && buf_space;
    assign o_s_axis_tready = !r_in_valid || buf_space;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;
    assign pop             = buf_valid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_in_mode <= i_s_axis_tuser[0];
            r_in_byte <= i_s_axis_tdata;
            r_in_eom  <= i_s_axis_tlast;
        end
    end

    ltd_parser #(
        .MAX_STRING_LEN(MAX_STRING_LEN)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (advance),
        .i_mode     (r_in_mode),
        .i_byte     (r_in_byte),
        .i_eom      (r_in_eom),
        .o_res_valid(res_valid),
        .o_res      (res)
    );

    ltd_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (advance && res_valid),
        .i_res      (res),
        .i_pop      (pop),
        .o_valid    (buf_valid),
        .o_has_space(buf_space),
        .o_level    (buf_level),
        .o_res      (head)
    );

    assign o_m_axis_tvalid = buf_valid;
    assign o_m_axis_tuser  = head.kind;
    assign o_m_axis_tdata  = {(OUT_DATA_W - 42)'(0), head.error_code, head.payload_byte,
                              head.value};

    `LTD_ASSERT_SAME(a_level_bound, i_clk, i_rst_n, 1'b1, buf_level != 2'd3)
    `LTD_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !buf_space, r_in_valid)
    `LTD_ASSERT_SAME(a_payload_clean, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser == K_PAYLOAD,
        head.value == 31'd0 && head.error_code == E_PREFIX)
    `LTD_ASSERT_SAME(a_err_code, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser == K_ERR,
        head.error_code <= E_TRUNC && head.value == 31'd0)

endmodule

// ===== sv/ltd_parser.sv =====
// Token parser: phase register, number accumulator and payload counter,
// with single-pass next-state and result logic. Depends on ltd_pkg.
module ltd_parser #(
    parameter int MAX_STRING_LEN = ltd_pkg::MAX_STRING_LEN_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic             i_mode,
    input  logic [7:0]       i_byte,
    input  logic             i_eom,
    output logic             o_res_valid,
    output ltd_pkg::t_result o_res
);
    import ltd_pkg::*;

    localparam int LenW = $clog2(MAX_STRING_LEN + 1);
    localparam logic [34:0] StrLimit = 35'(MAX_STRING_LEN);

    t_phase            r_phase, n_phase;
    logic [30:0]       r_acc, n_acc;
    logic [LenW-1:0]   r_rem, n_rem;
    logic              r_lk, n_lk;

    logic              is_digit;
    logic [3:0]        digit;
    logic [34:0]       acc_ext;
    logic [34:0]       next_num;
    logic [34:0]       limit;
    logic              err;
    logic              done;
    t_err              ecode;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign digit    = 4'(i_byte - CH_ZERO);
    assign acc_ext  = {4'b0, r_acc};
    // acc * 10 + digit as shift-add
    assign next_num = (acc_ext << 3) + (acc_ext << 1) + {31'b0, digit};
    assign limit    = r_lk ? StrLimit : INT_LIMIT;

    always_comb begin
        n_phase     = r_phase;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_lk        = r_lk;
        err         = 1'b0;
        done        = 1'b0;
        ecode       = E_PREFIX;
        o_res_valid = 1'b0;
        o_res       = '{kind: K_PAYLOAD, error_code: E_PREFIX, payload_byte: 8'd0,
                        value: 31'd0};

        unique case (r_phase)
            PH_PFX1: begin
                n_lk  = i_mode;
                n_acc = '0;
                n_rem = '0;
                if (i_byte == CH_HASH) n_phase = PH_PFX2;
                else err = 1'b1;
            end
            PH_PFX2: begin
                if (i_byte == CH_COLON) n_phase = PH_DIG1;
                else err = 1'b1;
            end
            PH_DIG1, PH_DIGN: begin
                if (is_digit) begin
                    if (next_num > limit) begin
                        err   = 1'b1;
                        ecode = E_LARGE;
                    end else begin
                        n_acc   = next_num[30:0];
                        n_phase = PH_DIGN;
                    end
                end else if (i_byte == CH_TILDE) begin
                    if (r_phase == PH_DIG1) begin
                        err   = 1'b1;
                        ecode = E_NODIGIT;
                    end else if (!r_lk) begin
                        o_res_valid = 1'b1;
                        o_res.kind  = K_INT;
                        o_res.value = r_acc;
                        done        = 1'b1;
                    end else begin
                        // string length never exceeds the limit, fits the counter
                        n_rem   = r_acc[LenW-1:0];
                        n_phase = PH_SPFX1;
                    end
                end else begin
                    err   = 1'b1;
                    ecode = E_DIGIT;
                end
            end
            PH_SPFX1: begin
                if (i_byte == CH_HASH) n_phase = PH_SPFX2;
                else err = 1'b1;
            end
            PH_SPFX2: begin
                if (i_byte == CH_COLON) n_phase = (r_rem == '0) ? PH_SSUF : PH_PAYLOAD;
                else err = 1'b1;
            end
            PH_PAYLOAD: begin
                if (!i_eom) begin
                    o_res_valid        = 1'b1;
                    o_res.kind         = K_PAYLOAD;
                    o_res.payload_byte = i_byte;
                end
                n_rem = r_rem - LenW'(1);
                if (r_rem == LenW'(1)) n_phase = PH_SSUF;
            end
            PH_SSUF: begin
                if (i_byte == CH_TILDE) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = K_STR;
                    o_res.value = r_acc;
                    done        = 1'b1;
                end else begin
                    err   = 1'b1;
                    ecode = E_SUFFIX;
                end
            end
            PH_DROP: done = 1'b1;
            default: done = 1'b1;
        endcase

        if (err) begin
            o_res_valid      = 1'b1;
            o_res.kind       = K_ERR;
            o_res.value      = 31'd0;
            o_res.payload_byte = 8'd0;
            o_res.error_code = ecode;
            n_phase          = PH_DROP;
        end else if (done) begin
            if (n_phase != PH_DROP) n_phase = PH_PFX1;
        end else if (i_eom) begin
            o_res_valid        = 1'b1;
            o_res.kind         = K_ERR;
            o_res.value        = 31'd0;
            o_res.payload_byte = 8'd0;
            o_res.error_code   = E_TRUNC;
        end

        if (i_eom) n_phase = PH_PFX1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PFX1;
            r_acc   <= '0;
            r_rem   <= '0;
            r_lk    <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_rem   <= n_rem;
            r_lk    <= n_lk;
        end
    end

endmodule

// ===== sv/ltd_out_buf.sv =====
// Two-entry result buffer between the parser and the output stream.
// Depends on ltd_pkg for the result type.
module ltd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ltd_pkg::t_result i_res,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_has_space,
    output logic [1:0]       o_level,
    output ltd_pkg::t_result o_res
);
    import ltd_pkg::*;

    t_result    r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_level, n_level;

    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) n_level = r_level + 2'd1;
        else if (!i_push && i_pop) n_level = r_level - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_level <= n_level;
        end
    end

    assign o_valid     = (r_level != 2'd0);
    assign o_has_space = (r_level != 2'd2);
    assign o_level     = r_level;
    assign o_res       = r_mem[r_rd];

endmodule

// ===== tb/ltd_token_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the token deframer: tracks parser state from accepted input
// beats and checks every result beat in order. Depends on ltd_pkg only.
module ltd_token_checker #(
    parameter int MAX_LEN = ltd_pkg::MAX_STRING_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [7:0]                     i_s_tdata,   // in_byte
    input  logic [0:0]                     i_s_tuser,   // mode
    input  logic                           i_s_tlast,   // end_of_message
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // value[30:0], payload_byte[38:31], error_code[41:39], zeros above
    input  logic [ltd_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [1:0]                     i_m_tuser,   // kind
    output int                             o_fail_count,
    output int                             o_results_owed
);
    import ltd_pkg::*;

    localparam int LenW = $clog2(MAX_LEN + 1);

    t_phase          parse_phase = PH_PFX1;
    logic [30:0]     number = '0;
    logic [LenW-1:0] payload_left = '0;
    logic            str_token = 1'b0;
    t_result         results_due[$];
    int              fails = 0;

    // Advances the parser by one byte; returns 1 when the byte yields a result.
    function automatic bit parse_byte(input logic mode, input logic [7:0] c,
                                      input logic eom, output t_result r);
        bit              fault;
        bit              closed;
        bit              produced;
        t_err            code;
        longint unsigned grown;
        longint unsigned ceiling;
        r        = '0;
        fault    = 1'b0;
        closed   = 1'b0;
        produced = 1'b0;
        code     = E_PREFIX;
        case (parse_phase)
            PH_PFX1: begin
                str_token    = mode;
                number       = '0;
                payload_left = '0;
                if (c == CH_HASH) parse_phase = PH_PFX2;
                else fault = 1'b1;
            end
            PH_PFX2: begin
                if (c == CH_COLON) parse_phase = PH_DIG1;
                else fault = 1'b1;
            end
            PH_DIG1, PH_DIGN: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    ceiling = str_token ? MAX_LEN : INT_LIMIT;
                    grown   = number * 64'd10 + (c - CH_ZERO);
                    if (grown > ceiling) begin
                        fault = 1'b1;
                        code  = E_LARGE;
                    end else begin
                        number      = grown[30:0];
                        parse_phase = PH_DIGN;
                    end
                end else if (c == CH_TILDE) begin
                    if (parse_phase == PH_DIG1) begin
                        fault = 1'b1;
                        code  = E_NODIGIT;
                    end else if (!str_token) begin
                        r.kind   = K_INT;
                        r.value  = number;
                        produced = 1'b1;
                        closed   = 1'b1;
                    end else begin
                        payload_left = number[LenW-1:0];
                        parse_phase  = PH_SPFX1;
                    end
                end else begin
                    fault = 1'b1;
                    code  = E_DIGIT;
                end
            end
            PH_SPFX1: begin
                if (c == CH_HASH) parse_phase = PH_SPFX2;
                else fault = 1'b1;
            end
            PH_SPFX2: begin
                if (c != CH_COLON) fault = 1'b1;
                else if (payload_left == 0) parse_phase = PH_SSUF;
                else parse_phase = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                // a payload byte flagged as last is swallowed; truncation reported instead
                if (!eom) begin
                    r.kind         = K_PAYLOAD;
                    r.payload_byte = c;
                    produced       = 1'b1;
                end
                if (payload_left != 0) payload_left--;
                if (payload_left == 0) parse_phase = PH_SSUF;
            end
            PH_SSUF: begin
                if (c == CH_TILDE) begin
                    r.kind   = K_STR;
                    r.value  = number;
                    produced = 1'b1;
                    closed   = 1'b1;
                end else begin
                    fault = 1'b1;
                    code  = E_SUFFIX;
                end
            end
            default: closed = 1'b1;
        endcase
        if (fault) begin
            r            = '0;
            r.kind       = K_ERR;
            r.error_code = code;
            produced     = 1'b1;
            parse_phase  = PH_DROP;
        end else if (closed) begin
            if (parse_phase != PH_DROP) parse_phase = PH_PFX1;
        end else if (eom) begin
            r            = '0;
            r.kind       = K_ERR;
            r.error_code = E_TRUNC;
            produced     = 1'b1;
        end
        if (eom) parse_phase = PH_PFX1;
        return produced;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result due;
        t_result seen;
        if (!i_rst_n) begin
            parse_phase  = PH_PFX1;
            number       = '0;
            payload_left = '0;
            str_token    = 1'b0;
            results_due.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                seen.kind         = t_kind'(i_m_tuser);
                seen.value        = i_m_tdata[30:0];
                seen.payload_byte = i_m_tdata[38:31];
                seen.error_code   = t_err'(i_m_tdata[41:39]);
                if (results_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: result beat with none outstanding:", $time,
                                 " kind=%0d value=%0d byte=%02h err=%0d",
                                 seen.kind, seen.value, seen.payload_byte,
                                 seen.error_code);
                end else begin
                    due = results_due.pop_front();
                    if (seen !== due || i_m_tdata[OUT_DATA_W-1:42] !== '0) begin
                        fails++;
                        if (fails <= 10)
                            $display("%0t: result mismatch: exp kind=%0d value=%0d byte=%02h err=%0d",
                                     $time, due.kind, due.value, due.payload_byte,
                                     due.error_code,
                                     " | got kind=%0d value=%0d byte=%02h err=%0d pad=%0h",
                                     seen.kind, seen.value, seen.payload_byte,
                                     seen.error_code, i_m_tdata[OUT_DATA_W-1:42]);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (parse_byte(i_s_tuser[0], i_s_tdata, i_s_tlast, due))
                    results_due.push_back(due);
            end
        end
        o_results_owed <= results_due.size();
        o_fail_count   <= fails;
    end

endmodule

// ===== tb/length_prefixed_token_deframer_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the token deframer testbench: clock, reset, message stimulus and verdict.
// Depends on ltd_pkg, the deframer RTL and ltd_token_checker.
module length_prefixed_token_deframer_unit_tb;
    import ltd_pkg::*;

    localparam int MAX_LEN        = MAX_STRING_LEN_DEF;
    localparam int PHASE_BEATS    = 330;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct {
        bit         mode;
        logic [7:0] data;
    } t_msg_byte;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [7:0]            i_s_axis_tdata = '0;  // in_byte
    logic [0:0]            i_s_axis_tuser = '0;  // mode
    logic                  i_s_axis_tlast = 1'b0; // end_of_message
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    // value[30:0], payload_byte[38:31], error_code[41:39], zeros above
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [1:0]            o_m_axis_tuser;       // kind

    int        src_idle_pct = 0;
    int        sink_stall_pct = 0;
    int        beats_sent = 0;
    bit        settling = 1'b0;
    int        fail_count;
    int        results_owed;
    t_msg_byte msg[$];

    always #1 i_clk = ~i_clk;

    length_prefixed_token_deframer_unit #(
        .MAX_STRING_LEN(MAX_LEN)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    ltd_token_checker #(
        .MAX_LEN(MAX_LEN)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (i_s_axis_tvalid),
        .i_s_tready     (o_s_axis_tready),
        .i_s_tdata      (i_s_axis_tdata),
        .i_s_tuser      (i_s_axis_tuser),
        .i_s_tlast      (i_s_axis_tlast),
        .i_m_tvalid     (o_m_axis_tvalid),
        .i_m_tready     (i_m_axis_tready),
        .i_m_tdata      (o_m_axis_tdata),
        .i_m_tuser      (o_m_axis_tuser),
        .o_fail_count   (fail_count),
        .o_results_owed (results_owed)
    );

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic void push_beat(bit mode, logic [7:0] data);
        t_msg_byte b;
        b.mode = mode;
        b.data = data;
        msg.push_back(b);
    endfunction

    // mode only matters on a token's first byte; elsewhere it is left random
    function automatic void append_text(bit kind, bit starts_token, string s);
        for (int i = 0; i < s.len(); i++)
            push_beat((i == 0 && starts_token) ? kind : bit'($urandom_range(0, 1)), s[i]);
    endfunction

    // Sends the queued message, end_of_message on its last beat. Called at a falling edge.
    task automatic send_message();
        foreach (msg[i]) begin
            while ($urandom_range(0, 99) < src_idle_pct) begin
                i_s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= msg[i].data;
            i_s_axis_tuser  <= msg[i].mode;
            i_s_axis_tlast  <= (i == msg.size() - 1);
            @(posedge i_clk);
            while (!o_s_axis_tready) @(posedge i_clk);
            @(negedge i_clk);
        end
        beats_sent += msg.size();
        msg.delete();
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (results_owed != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (settling || !i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                    || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("** length_prefixed_token_deframer_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int              tokens;
        int              pick;
        int              len;
        int              flaw;
        int              keep;
        int              phase_goal;
        bit              cut;
        longint unsigned num;
        string           digits;
        string           specials;
        specials = "#:~09";
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero-length string, no digits, bad prefix, too large,
        // truncated payload, bad suffix, integer then bad digit
        append_text(1'b1, 1'b1, "#:0~#:~");
        send_message();
        append_text(1'b0, 1'b1, "#:~");
        send_message();
        append_text(1'b0, 1'b1, "x");
        send_message();
        append_text(1'b1, 1'b1, "#:4097");
        send_message();
        append_text(1'b1, 1'b1, "#:1~#:");
        push_beat(1'b0, 8'hFF);
        send_message();
        append_text(1'b1, 1'b1, "#:1~#:");
        push_beat(1'b1, 8'h00);
        append_text(1'b0, 1'b0, "!");
        send_message();
        append_text(1'b0, 1'b1, "#:0~#:5x");
        send_message();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 56; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 56; end
                default: begin src_idle_pct = 35; sink_stall_pct = 35; end
            endcase
            phase_goal = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_goal) begin
                tokens = $urandom_range(1, 3);
                cut    = 1'b0;
                for (int t = 0; t < tokens && !cut; t++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45) begin
                        case ($urandom_range(0, 3))
                            0: num = 64'($urandom_range(0, 9));
                            1: num = 64'($urandom_range(0, 99999));
                            2: num = 64'($urandom & 32'h7FFF_FFFF);
                            default: begin
                                // straddle the 31-bit limit, or go far past it
                                if ($urandom_range(0, 1))
                                    num = 64'd2147483645 + $urandom_range(0, 4);
                                else
                                    num = 64'd10000000000 * $urandom_range(1, 9) + $urandom;
                            end
                        endcase
                        digits = $sformatf("%0d", num);
                        if ($urandom_range(0, 7) == 0)
                            repeat ($urandom_range(1, 2)) digits = {"0", digits};
                        append_text(1'b0, 1'b1, {"#:", digits, "~"});
                    end else if (pick < 85) begin
                        pick = $urandom_range(0, 9);
                        if (pick < 7) len = $urandom_range(0, 4);
                        else if (pick < 9) len = $urandom_range(5, 40);
                        else if ($urandom_range(0, 3) != 0)
                            len = MAX_LEN - 1 + $urandom_range(0, 2);
                        else len = 99999;
                        append_text(1'b1, 1'b1, $sformatf("#:%0d~#:", len));
                        if (len > 40) begin
                            // long payloads are cut short by end of message
                            repeat (3) push_beat(1'($urandom_range(0, 1)),
                                                 8'($urandom_range(0, 255)));
                            cut = 1'b1;
                        end else begin
                            repeat (len) push_beat(1'($urandom_range(0, 1)),
                                                   8'($urandom_range(0, 255)));
                            append_text(1'b0, 1'b0, "~");
                        end
                    end else begin
                        repeat ($urandom_range(1, 4)) begin
                            if ($urandom_range(0, 1))
                                push_beat(1'($urandom_range(0, 1)),
                                          8'($urandom_range(0, 255)));
                            else
                                push_beat(1'($urandom_range(0, 1)),
                                          specials[$urandom_range(0, specials.len() - 1)]);
                        end
                    end
                end
                flaw = $urandom_range(0, 99);
                if (flaw < 10) begin
                    msg[$urandom_range(0, msg.size() - 1)].data = 8'($urandom_range(0, 255));
                end else if (flaw < 20) begin
                    keep = $urandom_range(1, msg.size());
                    while (msg.size() > keep) void'(msg.pop_back());
                end
                send_message();
            end
            drain();
        end

        settling = 1'b1;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_owed == 0)
            $display("** length_prefixed_token_deframer_unit: PASSED **");
        else
            $display("** length_prefixed_token_deframer_unit: FAILED **");
        $finish;
    end

endmodule
